@@ sv/periodic_slot_task_dispatcher_top_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the periodic slot task dispatcher.
// All checks are sampled on i_clk and are off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_SLOT_TASK_DISPATCHER_TOP_DEFINES_SVH
`define PERIODIC_SLOT_TASK_DISPATCHER_TOP_DEFINES_SVH

// A condition that holds at every clock edge.
`define PSTD_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// A condition that implies another one in the same cycle.
`define PSTD_ASSERT_IMP(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (pre) |-> (post)) else $error(msg);

// A condition that implies another one in the next cycle.
`define PSTD_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (pre) |=> (post)) else $error(msg);

`endif

@@ sv/pstd_pkg.sv @@
// ----------------------------------------------------------------------------
// pstd_pkg
// Types and constants shared by the slot cells and the dispatcher top level.
// ----------------------------------------------------------------------------
package pstd_pkg;

    // Default number of task slots.
    localparam int SLOT_COUNT_DEF = 16;

    // Field widths fixed by the item formats.
    localparam int CMD_W      = 3;
    localparam int SLOT_W     = 8;
    localparam int INTERVAL_W = 16;
    localparam int TIME_W     = 32;
    localparam int RUN_SLOT_W = 6;
    localparam int COUNT_W    = 6;

    // Command codes.
    typedef enum logic [CMD_W-1:0] {
        CMD_INIT        = 3'd0,
        CMD_REGISTER    = 3'd1,
        CMD_UNREGISTER  = 3'd2,
        CMD_SUSPEND     = 3'd3,
        CMD_RESUME      = 3'd4,
        CMD_QUERY       = 3'd5,
        CMD_TICK        = 3'd6,
        CMD_RUN_PENDING = 3'd7
    } t_cmd;

    // Input item.
    typedef struct packed {
        logic [CMD_W-1:0]      command;
        logic [SLOT_W-1:0]     slot;
        logic [INTERVAL_W-1:0] period_ms;
        logic [TIME_W-1:0]     now_ms;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic                  ok;
        logic                  is_registered;
        logic                  is_suspended;
        logic                  run_valid;
        logic [RUN_SLOT_W-1:0] run_slot;
        logic [TIME_W-1:0]     run_time;
        logic [COUNT_W-1:0]    run_count;
        logic                  last;
    } t_out_item;

    // Table update broadcast to every cell; the per-cell select qualifies all but init.
    typedef struct packed {
        logic                  init;
        logic                  reg_w;
        logic                  unreg;
        logic                  sus_w;
        logic                  sus_val;
        logic [INTERVAL_W-1:0] interval;
    } t_cell_cmd;

    // Scan control broadcast to every cell.
    typedef struct packed {
        logic              step;
        logic              run_all;
        logic [TIME_W-1:0] now;
    } t_scan_bus;

    // Status returned by one cell.
    typedef struct packed {
        logic tok;
        logic emit;
        logic reg_hit;
        logic sus_hit;
    } t_cell_stat;

endpackage

@@ sv/pstd_cell.sv @@
// ----------------------------------------------------------------------------
// pstd_cell
// One task slot: holds the slot's flags, interval and last-run time, and
// passes the scan token on to the next cell.
// ----------------------------------------------------------------------------
module pstd_cell import pstd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_cmd  i_cmd,
    input  logic       i_sel,
    input  t_scan_bus  i_scan,
    input  logic       i_tok,
    output t_cell_stat o_stat
);

    logic                  r_registered;
    logic                  r_suspended;
    logic                  r_first;
    logic                  r_tok;
    logic [INTERVAL_W-1:0] r_interval;
    logic [TIME_W-1:0]     r_last_run;

    logic [TIME_W-1:0]     w_elapsed;
    logic                  w_due;
    logic                  w_emit;
    logic                  w_stamp;

    // The slot is due on its first run, on run pending, or once the
    // wrapping elapsed time reaches the interval.
    assign w_elapsed = i_scan.now - r_last_run;
    assign w_due     = i_scan.run_all || r_first
                       || (w_elapsed >= {{(TIME_W-INTERVAL_W){1'b0}}, r_interval});
    assign w_emit    = r_tok && r_registered && !r_suspended && w_due;
    assign w_stamp   = i_scan.step && w_emit && !i_scan.run_all;

    // Flags and token.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_registered <= 1'b0;
            r_suspended  <= 1'b0;
            r_first      <= 1'b0;
            r_tok        <= 1'b0;
        end else begin
            if (i_scan.step) begin
                r_tok <= i_tok;
            end
            if (i_cmd.init) begin
                r_registered <= 1'b0;
                r_suspended  <= 1'b0;
                r_first      <= 1'b0;
            end else if (i_sel && i_cmd.reg_w) begin
                r_registered <= 1'b1;
                r_suspended  <= 1'b0;
                r_first      <= 1'b1;
            end else if (i_sel && i_cmd.unreg) begin
                r_registered <= 1'b0;
                r_suspended  <= 1'b0;
                r_first      <= 1'b0;
            end else if (i_sel && i_cmd.sus_w) begin
                r_suspended <= i_cmd.sus_val;
            end else if (w_stamp) begin
                r_first <= 1'b0;
            end
        end
    end

    // Timing payload, written by register and by a tick dispatch.
    always_ff @(posedge i_clk) begin
        if (i_sel && i_cmd.reg_w) begin
            r_interval <= i_cmd.interval;
            r_last_run <= '0;
        end else if (w_stamp) begin
            r_last_run <= i_scan.now;
        end
    end

    assign o_stat.tok     = r_tok;
    assign o_stat.emit    = w_emit;
    assign o_stat.reg_hit = i_sel && r_registered;
    assign o_stat.sus_hit = i_sel && r_suspended;

endmodule

@@ sv/periodic_slot_task_dispatcher_top.sv @@
// ----------------------------------------------------------------------------
// periodic_slot_task_dispatcher_top
// Fixed-priority periodic task dispatcher built as a chain of slot cells.
//
//   Channel | Direction | Valid       | Stall       | Payload
//   in      | input     | i_in_valid  | o_in_stall  | i_in_item  (t_in_item)
//   out     | output    | o_out_valid | i_out_stall | o_out_item (t_out_item)
//
// Slot commands (init, register, unregister, suspend, resume, query) give one
// item each. Tick and run pending walk a token down the cell chain one cell
// per cycle, except while the output stalls, and give one item per dispatched
// slot and a final item with the dispatch count.
// The scan holds in place while a result waits in the stalled output register.
// Reset is synchronous and clears all flags; the table starts empty.
// ----------------------------------------------------------------------------
`include "periodic_slot_task_dispatcher_top_defines.svh"

module periodic_slot_task_dispatcher_top import pstd_pkg::*; #(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_FINAL = 3'b100
    } t_state;

    t_state                r_state;
    logic                  r_ready;
    logic [RUN_SLOT_W-1:0] r_idx;
    logic [COUNT_W-1:0]    r_count;
    logic [TIME_W-1:0]     r_now;
    logic                  r_run_all;
    logic                  r_out_valid;
    t_out_item             r_out;

    t_cmd                  w_cmd;
    logic                  w_accept;
    logic                  w_adv;
    logic                  w_start;
    logic                  w_load;
    logic                  w_in_range;
    logic                  w_addr_ok;
    logic                  w_reg_any;
    logic                  w_sus_any;
    logic                  w_emit_any;
    logic                  w_scan_done;
    logic [SLOT_COUNT-1:0] w_sel;
    logic [SLOT_COUNT-1:0] w_tok_vec;
    logic [SLOT_COUNT-1:0] w_emit_vec;
    logic [SLOT_COUNT-1:0] w_reg_vec;
    logic [SLOT_COUNT-1:0] w_sus_vec;
    logic [SLOT_COUNT-1:0] w_tok_in;
    t_cell_stat            w_stat [SLOT_COUNT];
    t_cell_cmd             w_cell_cmd;
    t_scan_bus             w_scan;
    t_out_item             w_single;
    t_out_item             n_out;

    // Handshake.
    assign w_adv      = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE) || (r_out_valid && i_out_stall);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_cmd      = t_cmd'(i_in_item.command);

    // Slot select decode and the cell chain.
    genvar gi;
    generate
        for (gi = 0; gi < SLOT_COUNT; gi++) begin : g_cell
            assign w_sel[gi] = (i_in_item.slot == SLOT_W'(gi));
            if (gi == 0) begin : g_head
                assign w_tok_in[gi] = w_start;
            end else begin : g_link
                assign w_tok_in[gi] = w_stat[gi-1].tok;
            end
            pstd_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (w_cell_cmd),
                .i_sel   (w_sel[gi]),
                .i_scan  (w_scan),
                .i_tok   (w_tok_in[gi]),
                .o_stat  (w_stat[gi])
            );
            assign w_tok_vec[gi]  = w_stat[gi].tok;
            assign w_emit_vec[gi] = w_stat[gi].emit;
            assign w_reg_vec[gi]  = w_stat[gi].reg_hit;
            assign w_sus_vec[gi]  = w_stat[gi].sus_hit;
        end
    endgenerate

    assign w_in_range = |w_sel;
    assign w_addr_ok  = r_ready && w_in_range;
    assign w_reg_any  = |w_reg_vec;
    assign w_sus_any  = |w_sus_vec;
    assign w_emit_any = |w_emit_vec;

    // Scan control.
    assign w_start        = w_accept && r_ready
                            && ((w_cmd == CMD_TICK) || (w_cmd == CMD_RUN_PENDING));
    assign w_scan.step    = w_start || ((r_state == ST_SCAN) && w_adv);
    assign w_scan.run_all = r_run_all;
    assign w_scan.now     = r_now;
    assign w_scan_done    = (r_state == ST_SCAN) && w_tok_vec[SLOT_COUNT-1] && w_adv;

    // Command decode: table updates and the single result.
    always_comb begin
        w_cell_cmd          = '0;
        w_cell_cmd.interval = i_in_item.period_ms;
        w_single            = '0;
        w_single.last       = 1'b1;
        unique case (w_cmd) inside
            CMD_INIT: begin
                w_cell_cmd.init = w_accept;
                w_single.ok     = 1'b1;
            end
            CMD_REGISTER: begin
                w_single.ok      = w_addr_ok && !w_reg_any;
                w_cell_cmd.reg_w = w_accept && w_single.ok;
            end
            CMD_UNREGISTER: begin
                w_single.ok      = w_addr_ok && w_reg_any;
                w_cell_cmd.unreg = w_accept && w_single.ok;
            end
            CMD_SUSPEND, CMD_RESUME: begin
                w_single.ok        = w_addr_ok && w_reg_any;
                w_cell_cmd.sus_w   = w_accept && w_single.ok;
                w_cell_cmd.sus_val = (w_cmd == CMD_SUSPEND);
            end
            CMD_QUERY: begin
                w_single.ok            = w_addr_ok;
                w_single.is_registered = w_addr_ok && w_reg_any;
                w_single.is_suspended  = w_addr_ok && w_sus_any;
            end
            CMD_TICK, CMD_RUN_PENDING: begin
                // Only reaches the output when the table is not initialized.
                w_single.ok = 1'b0;
            end
            default: begin
                w_single.ok = 1'b0;
            end
        endcase
    end

    // Next output item.
    always_comb begin
        n_out = w_single;
        unique case (r_state)
            ST_SCAN: begin
                n_out           = '0;
                n_out.ok        = 1'b1;
                n_out.run_valid = 1'b1;
                n_out.run_slot  = r_idx;
                n_out.run_time  = r_run_all ? '0 : r_now;
            end
            ST_FINAL: begin
                n_out           = '0;
                n_out.ok        = 1'b1;
                n_out.run_count = r_count;
                n_out.last      = 1'b1;
            end
            default: begin
                n_out = w_single;
            end
        endcase
    end

    assign w_load = (w_accept && !w_start)
                    || ((r_state == ST_SCAN) && w_emit_any)
                    || (r_state == ST_FINAL);

    // Sequencer and ready flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ready <= 1'b0;
            r_idx   <= '0;
            r_count <= '0;
        end else begin
            if (w_accept && (w_cmd == CMD_INIT)) begin
                r_ready <= 1'b1;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_start) begin
                        r_state <= ST_SCAN;
                        r_idx   <= '0;
                        r_count <= '0;
                    end
                end
                ST_SCAN: begin
                    if (w_adv) begin
                        r_idx <= r_idx + RUN_SLOT_W'(1);
                        if (w_emit_any) begin
                            r_count <= r_count + COUNT_W'(1);
                        end
                        if (w_tok_vec[SLOT_COUNT-1]) begin
                            r_state <= ST_FINAL;
                        end
                    end
                end
                ST_FINAL: begin
                    if (w_adv) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Scan parameters captured when a scan starts.
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_now     <= i_in_item.now_ms;
            r_run_all <= (w_cmd == CMD_RUN_PENDING);
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Checks on the token chain and the sequencer.
    `PSTD_ASSERT_ALWAYS(a_tok_onehot0, $onehot0(w_tok_vec), "more than one scan token")
    `PSTD_ASSERT_IMP(a_idle_no_tok, r_state == ST_IDLE, w_tok_vec == '0, "token while idle")
    `PSTD_ASSERT_IMP(a_emit_in_scan, w_emit_any, r_state == ST_SCAN, "dispatch outside scan")
    `PSTD_ASSERT_NEXT(a_scan_to_final, w_scan_done, r_state == ST_FINAL, "scan did not finish")
    `PSTD_ASSERT_IMP(a_last_no_run, r_out_valid && r_out.last, !r_out.run_valid, "final dispatch")

endmodule
